// ===== rtl/core/iuca_pkg.sv =====
// iuca_pkg: shared types and codes for the iso14443-a uid cascade assembler
// no dependencies; imported by iuca_step and iso14443a_uid_cascade_assembler
package iuca_pkg;

  localparam logic [1:0] OP_ATQA     = 2'd0;
  localparam logic [1:0] OP_ANTICOLL = 2'd1;
  localparam logic [1:0] OP_SELECT   = 2'd2;

  localparam logic [2:0] XS_OK       = 3'd0;
  localparam logic [2:0] XS_NO_CARD  = 3'd1;
  localparam logic [2:0] XS_TIMEOUT  = 3'd2;
  localparam logic [2:0] XS_ERR_BITS = 3'd3;
  localparam logic [2:0] XS_RX_LONG  = 3'd4;

  localparam logic [3:0] ST_PENDING   = 4'd0;
  localparam logic [3:0] ST_DONE      = 4'd1;
  localparam logic [3:0] ST_NO_CARD   = 4'd2;
  localparam logic [3:0] ST_TIMEOUT   = 4'd3;
  localparam logic [3:0] ST_BAD_REPLY = 4'd4;
  localparam logic [3:0] ST_CHECK     = 4'd5;
  localparam logic [3:0] ST_SIZE      = 4'd6;
  localparam logic [3:0] ST_LINK      = 4'd7;
  localparam logic [3:0] ST_NOT_READY = 4'd8;
  localparam logic [3:0] ST_ORDER     = 4'd9;

  localparam logic [7:0] TAG_BYTE = 8'h88;
  localparam logic [7:0] MORE_BIT = 8'h04;
  localparam logic [7:0] SEL_CL1  = 8'h93;

  localparam logic [2:0] ATQA_LEN   = 3'd2;
  localparam logic [2:0] ANTICL_LEN = 3'd5;
  localparam logic [2:0] SEL_LEN    = 3'd3;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_ANTICOLL = 3'b010,
    PH_SELECT   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  next_cmd;
    phase_t      phase_nxt;
    logic [1:0]  level_nxt;
    logic [15:0] atqa_nxt;
    logic        lb_load;
    logic        wr_en;
    logic        skip_tag;
    logic        done;
  } step_t;

  function automatic logic [7:0] sel_code(input logic [1:0] lvl);
    sel_code = SEL_CL1 + {5'd0, lvl, 1'b0};
  endfunction

  function automatic logic [3:0] xfer_code(input logic [2:0] xs);
    case (xs)
      XS_NO_CARD:  xfer_code = ST_NO_CARD;
      XS_TIMEOUT:  xfer_code = ST_TIMEOUT;
      XS_ERR_BITS: xfer_code = ST_BAD_REPLY;
      XS_RX_LONG:  xfer_code = ST_SIZE;
      default:     xfer_code = ST_LINK;
    endcase
  endfunction

endpackage

// ===== rtl/core/iuca_step.sv =====
// iuca_step: per-item checks and next-state decision of the cascade sequencer
// depends on iuca_pkg
module iuca_step import iuca_pkg::*; #(
  parameter int UID_MAX_BYTES = 10,
  parameter int MAX_LEVELS    = 3,
  localparam int CNT_W        = $clog2(UID_MAX_BYTES + 1)
) (
  input  logic [1:0]       opcode_i,
  input  logic [2:0]       xfer_status_i,
  input  logic [2:0]       resp_len_i,
  input  logic [2:0]       resp_last_bits_i,
  input  logic [39:0]      resp_data_i,
  input  logic             sak_crc_ok_i,
  input  logic             reader_ready_i,
  input  phase_t           phase_i,
  input  logic [1:0]       level_i,
  input  logic [7:0]       lb_first_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [15:0]      atqa_i,
  output step_t            step_o,
  output logic [CNT_W-1:0] count_nxt_o,
  output logic [CNT_W-1:0] run_len_o
);

  logic [7:0]     b0, b1, b2, b3, b4;
  logic           tag;
  logic [CNT_W:0] sum;
  logic [2:0]     lvl_inc;

  assign b0 = resp_data_i[7:0];
  assign b1 = resp_data_i[15:8];
  assign b2 = resp_data_i[23:16];
  assign b3 = resp_data_i[31:24];
  assign b4 = resp_data_i[39:32];

  assign tag     = (lb_first_i == TAG_BYTE);
  assign sum     = {1'b0, count_i} + (CNT_W+1)'(tag ? 3 : 4);
  assign lvl_inc = {1'b0, level_i} + 3'd1;
  assign run_len_o = sum[CNT_W-1:0];

  always_comb begin
    step_o.status    = ST_PENDING;
    step_o.next_cmd  = 8'd0;
    step_o.phase_nxt = PH_IDLE;
    step_o.level_nxt = 2'd0;
    step_o.atqa_nxt  = atqa_i;
    step_o.lb_load   = 1'b0;
    step_o.wr_en     = 1'b0;
    step_o.skip_tag  = tag;
    step_o.done      = 1'b0;
    count_nxt_o      = '0;

    if (opcode_i == OP_ATQA) begin
      step_o.atqa_nxt = 16'd0;
      if (!reader_ready_i) begin
        step_o.status = ST_NOT_READY;
      end else if (xfer_status_i != XS_OK) begin
        step_o.status = xfer_code(xfer_status_i);
      end else if (resp_len_i != ATQA_LEN || resp_last_bits_i != 3'd0) begin
        step_o.status = ST_BAD_REPLY;
      end else begin
        step_o.atqa_nxt  = {b1, b0};
        step_o.phase_nxt = PH_ANTICOLL;
        step_o.next_cmd  = sel_code(2'd0);
      end
    end else if (opcode_i == OP_ANTICOLL && phase_i == PH_ANTICOLL) begin
      if (xfer_status_i != XS_OK) begin
        step_o.status = xfer_code(xfer_status_i);
      end else if (resp_len_i > ANTICL_LEN) begin
        step_o.status = ST_SIZE;
      end else if (resp_len_i != ANTICL_LEN) begin
        step_o.status = ST_BAD_REPLY;
      end else if ((b0 ^ b1 ^ b2 ^ b3) != b4) begin
        step_o.status = ST_CHECK;
      end else begin
        step_o.lb_load   = 1'b1;
        step_o.phase_nxt = PH_SELECT;
        step_o.level_nxt = level_i;
        step_o.next_cmd  = sel_code(level_i);
        count_nxt_o      = count_i;
      end
    end else if (opcode_i == OP_SELECT && phase_i == PH_SELECT) begin
      if (xfer_status_i != XS_OK) begin
        step_o.status = xfer_code(xfer_status_i);
      end else if (resp_len_i > SEL_LEN) begin
        step_o.status = ST_SIZE;
      end else if (resp_len_i != SEL_LEN) begin
        step_o.status = ST_BAD_REPLY;
      end else if (!sak_crc_ok_i) begin
        step_o.status = ST_CHECK;
      end else if (sum > (CNT_W+1)'(UID_MAX_BYTES)) begin
        step_o.status = ST_SIZE;
      end else begin
        step_o.wr_en = 1'b1;
        if ((b0 & MORE_BIT) == 8'd0) begin
          step_o.status = ST_DONE;
          step_o.done   = 1'b1;
        end else if (lvl_inc >= 3'(MAX_LEVELS)) begin
          step_o.status = ST_BAD_REPLY;
        end else begin
          step_o.phase_nxt = PH_ANTICOLL;
          step_o.level_nxt = lvl_inc[1:0];
          step_o.next_cmd  = sel_code(lvl_inc[1:0]);
          count_nxt_o      = sum[CNT_W-1:0];
        end
      end
    end else begin
      step_o.status = ST_ORDER;
    end
  end

endmodule

// ===== rtl/core/iso14443a_uid_cascade_assembler.sv =====
// iso14443a_uid_cascade_assembler: top level of the reader-side card identification sequencer
// depends on iuca_pkg and iuca_step
//
// usage: the in_ channel carries one item per card exchange (atqa reply, then per
// cascade level the anticollision reply and the select reply); the out_ channel
// carries results; cfg_wr_en/cfg_wr_data set reader_ready, written by the user only while
// the block is idle, which the block leaves unchecked. both channels use valid/stall; an item
// moves when valid is high and stall low. an accepted item is held in the input register, is
// evaluated and lands in the result register, which drives out_valid.
// items that give one result sustain one item per cycle while out_stall is low (the result
// register frees when taken).
// a completing select reply gives a run of uid_len results (3 to UID_MAX_BYTES), one per
// cycle while out_stall is low, from the uid buffer once the run is active; the next item
// waits in the input register, so a completion occupies the evaluation stage until its
// run ends.
// reset clears the channels, the sequencer (idle, level 0, no uid bytes), the
// held atqa and reader_ready; the uid buffer is not cleared.
// while out_stall is high the result holds and evaluation pauses; in_stall rises
// only once the input register is also full.
module iso14443a_uid_cascade_assembler import iuca_pkg::*; #(
  parameter int UID_MAX_BYTES = 10,
  parameter int MAX_LEVELS    = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_xfer_status,
  input  logic [2:0]  in_resp_len,
  input  logic [2:0]  in_resp_last_bits,
  input  logic [39:0] in_resp_data,
  input  logic        in_sak_crc_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [7:0]  out_next_cmd,
  output logic [7:0]  out_uid_byte,
  output logic [3:0]  out_uid_index,
  output logic [3:0]  out_uid_len,
  output logic [7:0]  out_sak,
  output logic [15:0] out_atqa,
  output logic        out_last
);

  localparam int CNT_W = $clog2(UID_MAX_BYTES + 1);
  localparam int IDX_W = $clog2(UID_MAX_BYTES);

  // input register
  logic        in_vld_r;
  logic [1:0]  opcode_r;
  logic [2:0]  xfer_status_r;
  logic [2:0]  resp_len_r;
  logic [2:0]  resp_last_bits_r;
  logic [39:0] resp_data_r;
  logic        sak_crc_ok_r;

  // sequencer state
  logic             reader_ready_r;
  phase_t           phase_r;
  logic [1:0]       level_r;
  logic [31:0]      level_bytes_r;
  logic [CNT_W-1:0] count_r;
  logic [15:0]      atqa_r;
  logic [7:0]       uid_store [UID_MAX_BYTES];

  // completion run
  logic             run_active_r;
  logic [IDX_W-1:0] run_idx_r;
  logic [CNT_W-1:0] run_len_r;
  logic [7:0]       run_sak_r;

  // result register
  logic        out_valid_r;
  logic [3:0]  out_status_r;
  logic [7:0]  out_next_cmd_r;
  logic [7:0]  out_uid_byte_r;
  logic [3:0]  out_uid_index_r;
  logic [3:0]  out_uid_len_r;
  logic [7:0]  out_sak_r;
  logic [15:0] out_atqa_r;
  logic        out_last_r;

  step_t            st;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] run_len_nxt;
  logic             out_load;
  logic             run_emit;
  logic             adv;
  logic             run_end;
  logic [CNT_W:0]   wr_sum [4];
  logic [IDX_W-1:0] wr_addr [4];

  iuca_step #(
    .UID_MAX_BYTES (UID_MAX_BYTES),
    .MAX_LEVELS    (MAX_LEVELS)
  ) u_step (
    .opcode_i         (opcode_r),
    .xfer_status_i    (xfer_status_r),
    .resp_len_i       (resp_len_r),
    .resp_last_bits_i (resp_last_bits_r),
    .resp_data_i      (resp_data_r),
    .sak_crc_ok_i     (sak_crc_ok_r),
    .reader_ready_i   (reader_ready_r),
    .phase_i          (phase_r),
    .level_i          (level_r),
    .lb_first_i       (level_bytes_r[7:0]),
    .count_i          (count_r),
    .atqa_i           (atqa_r),
    .step_o           (st),
    .count_nxt_o      (count_nxt),
    .run_len_o        (run_len_nxt)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign run_emit = run_active_r && out_load;
  assign adv      = in_vld_r && !run_active_r && out_load;
  assign in_stall = in_vld_r && !adv;
  assign run_end  = ({1'b0, run_idx_r} + (IDX_W+1)'(1)) == (IDX_W+1)'(run_len_r);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      wr_sum[k]  = {1'b0, count_r} + (CNT_W+1)'(k) - (CNT_W+1)'(st.skip_tag);
      wr_addr[k] = wr_sum[k][IDX_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      reader_ready_r <= 1'b0;
      phase_r        <= PH_IDLE;
      level_r        <= 2'd0;
      level_bytes_r  <= 32'd0;
      count_r        <= '0;
      atqa_r         <= 16'd0;
      run_active_r   <= 1'b0;
      run_idx_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        reader_ready_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        phase_r <= st.phase_nxt;
        level_r <= st.level_nxt;
        count_r <= count_nxt;
        atqa_r  <= st.atqa_nxt;
        if (st.lb_load) begin
          level_bytes_r <= resp_data_r[31:0];
        end
        if (st.done) begin
          run_active_r <= 1'b1;
          run_idx_r    <= '0;
        end
      end
      if (run_emit) begin
        if (run_end) begin
          run_active_r <= 1'b0;
        end else begin
          run_idx_r <= run_idx_r + IDX_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= run_emit || (adv && !st.done);
      end
    end
  end

  // payload registers and uid buffer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      opcode_r         <= in_opcode;
      xfer_status_r    <= in_xfer_status;
      resp_len_r       <= in_resp_len;
      resp_last_bits_r <= in_resp_last_bits;
      resp_data_r      <= in_resp_data;
      sak_crc_ok_r     <= in_sak_crc_ok;
    end
    if (adv && st.wr_en) begin
      for (int k = 0; k < 4; k++) begin
        if (k >= int'(st.skip_tag)) begin
          uid_store[wr_addr[k]] <= level_bytes_r[8*k +: 8];
        end
      end
    end
    if (adv && st.done) begin
      run_len_r <= run_len_nxt;
      run_sak_r <= resp_data_r[7:0];
    end
    if (run_emit) begin
      out_status_r    <= ST_DONE;
      out_next_cmd_r  <= 8'd0;
      out_uid_byte_r  <= uid_store[run_idx_r];
      out_uid_index_r <= 4'(run_idx_r);
      out_uid_len_r   <= 4'(run_len_r);
      out_sak_r       <= run_sak_r;
      out_atqa_r      <= atqa_r;
      out_last_r      <= run_end;
    end else if (adv && out_load) begin
      out_status_r    <= st.status;
      out_next_cmd_r  <= st.next_cmd;
      out_uid_byte_r  <= 8'd0;
      out_uid_index_r <= 4'd0;
      out_uid_len_r   <= 4'd0;
      out_sak_r       <= 8'd0;
      out_atqa_r      <= st.atqa_nxt;
      out_last_r      <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_next_cmd  = out_next_cmd_r;
  assign out_uid_byte  = out_uid_byte_r;
  assign out_uid_index = out_uid_index_r;
  assign out_uid_len   = out_uid_len_r;
  assign out_sak       = out_sak_r;
  assign out_atqa      = out_atqa_r;
  assign out_last      = out_last_r;

  // a completing select starts its run at the first buffer entry
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st.done |=> run_active_r && run_idx_r == '0)
    else $error("completion run did not start");

  // run index stays inside the assembled uid
  a_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
    run_active_r |-> (CNT_W+1)'(run_idx_r) < (CNT_W+1)'(run_len_r))
    else $error("run index beyond uid length");

  // a held input item is never dropped
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r)
    else $error("held item lost");

  // uid byte count never passes the buffer size
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(count_r) <= (CNT_W+1)'(UID_MAX_BYTES))
    else $error("uid count overflow");

  // error results carry no command and close the item
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_PENDING && out_status_r != ST_DONE
      |-> out_next_cmd_r == 8'd0 && out_last_r)
    else $error("error result malformed");

endmodule
